// ===== rtl/bba_pkg.sv =====
// Package for the buddy block allocator: request/response types,
// status codes, sequencer states and size-to-order helper. No dependencies.
package bba_pkg;

   localparam int unsigned OrdWidth = 5;

   typedef enum logic [1:0] {
      STATUS_DONE     = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_SIZE = 2'd2
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ARD,
      ST_ACHK,
      ST_SPLIT,
      ST_FRD,
      ST_FCHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        operation;
      logic [16:0] size;
      logic [15:0] address;
   } req_type;

   typedef struct packed {
      logic [15:0] block_address;
      logic [1:0]  status;
   } rsp_type;

   // ceil(log2(size)) for size >= 1; position of top set bit of size-1, plus one
   function automatic logic [OrdWidth-1:0] size_bits(input logic [16:0] size);
      logic [16:0]         n;
      logic [OrdWidth-1:0] bits;
      n    = size - 17'd1;
      bits = '0;
      for (int b = 0; b < 17; b++) begin
         if (n[b]) begin
            bits = OrdWidth'(b + 1);
         end
      end
      return bits;
   endfunction

endpackage

// ===== rtl/bba_map.sv =====
// Free-block bitmap memory: one bit per block, all orders stacked.
// One write port, one read port with registered read data. Does not use bba_pkg.
module bba_map #(
   parameter int unsigned Depth     = 1023,
   parameter int unsigned AddrWidth = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic                 wr_data,
   input  logic                 rd_en,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic                 rd_data
);

   logic mem [Depth];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/buddy_block_allocator.sv =====
// Buddy block allocator, top level: request sequencer over the free bitmap.
// Depends on bba_pkg and bba_map.
// After reset a clearing pass writes every bitmap entry, one per cycle
// (2^(POOL_ORDER-low+1)-1 entries, 1023 by default); no request is taken meanwhile.
// Allocate: scans bitmap entries (lowest address first, orders upward), then splits
// down an order at a time; free: merges with free buddies an order at a time.
// One request at a time; the response register lets the next request in while it waits.
module buddy_block_allocator #(
   parameter int unsigned POOL_ORDER = 16,
   parameter int unsigned MIN_ORDER  = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   // lowest order held in the map; the map shrinks to the pool block alone
   // when MIN_ORDER exceeds POOL_ORDER
   localparam int unsigned LowOrder  = (MIN_ORDER < POOL_ORDER) ? MIN_ORDER : POOL_ORDER;
   localparam int unsigned Depth     = (2 << (POOL_ORDER - LowOrder)) - 1;
   localparam int unsigned AddrWidth = (POOL_ORDER - LowOrder + 1 > 1) ?
                                       POOL_ORDER - LowOrder + 1 : 1;
   localparam logic [OrdWidth-1:0] PoolOrd = OrdWidth'(POOL_ORDER);
   localparam logic [OrdWidth-1:0] MinOrd  = OrdWidth'(MIN_ORDER);

   state_type                state_ff, state_in;
   logic [AddrWidth-1:0]     clr_ff, clr_in;
   logic                     op_ff, op_in;
   logic [OrdWidth-1:0]      req_ord_ff, req_ord_in;  // requested order k
   logic [OrdWidth-1:0]      ord_ff, ord_in;          // walking order
   logic [POOL_ORDER-1:0]    addr_ff, addr_in;        // block / free address
   logic [POOL_ORDER-1:0]    idx_ff, idx_in;          // scan position within order
   logic [1:0]               status_ff, status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     wr_en, wr_data, rd_en, rd_data;
   logic [AddrWidth-1:0]     wr_addr, rd_addr;

   logic [OrdWidth-1:0]      bits, k_calc;
   logic                     bad_size;
   logic [31:0]              base_cur, base_dn, addr32, a_in32, blk32, map32, buddy32;
   logic [31:0]              split32, out32;
   logic [OrdWidth-1:0]      ord_dn;

   bba_map #(
      .Depth     (Depth),
      .AddrWidth (AddrWidth)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // request order: round up, clamp to MIN_ORDER, out of range when zero or above the pool
   always_comb begin
      bits     = size_bits(req_data.size);
      k_calc   = (bits < MinOrd) ? MinOrd : bits;
      bad_size = (req_data.size == 17'd0) || (k_calc > PoolOrd);
      a_in32   = 32'(req_data.address) & ((32'd1 << POOL_ORDER) - 32'd1);
      a_in32   = a_in32 & ~((32'd1 << k_calc) - 32'd1);
   end

   // map index = (2^(POOL-order) - 1) + (addr >> order)
   always_comb begin
      ord_dn   = ord_ff - OrdWidth'(1);
      base_cur = (32'd1 << (PoolOrd - ord_ff)) - 32'd1;
      base_dn  = (32'd1 << (PoolOrd - ord_dn)) - 32'd1;
      addr32   = 32'(addr_ff);
      blk32    = 32'(idx_ff) << ord_ff;
      map32    = base_cur + (addr32 >> ord_ff);
      buddy32  = base_cur + ((addr32 >> ord_ff) ^ 32'd1);
      split32  = base_dn + (addr32 >> ord_dn) + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      req_ord_ff <= req_ord_in;
      ord_ff     <= ord_in;
      addr_ff    <= addr_in;
      idx_ff     <= idx_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      req_ord_in   = req_ord_ff;
      ord_in       = ord_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      out32        = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // only the whole-pool block (entry 0) starts free
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = (clr_ff == '0);
            clr_in  = clr_ff + AddrWidth'(1);
            if (32'(clr_ff) == Depth - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in      = req_data.operation;
               req_ord_in = k_calc;
               ord_in     = k_calc;
               addr_in    = a_in32[POOL_ORDER-1:0];
               idx_in     = '0;
               status_in  = STATUS_DONE;
               if (bad_size) begin
                  status_in = STATUS_BAD_SIZE;
                  state_in  = ST_DONE;
               end else if (req_data.operation == OP_ALLOC) begin
                  state_in = ST_ARD;
               end else begin
                  state_in = ST_FRD;
               end
            end
         end
         ST_ARD: begin
            rd_en    = 1'b1;
            rd_addr  = AddrWidth'(base_cur + 32'(idx_ff));
            state_in = ST_ACHK;
         end
         ST_ACHK: begin
            if (rd_data) begin
               // take it; split down from this order
               wr_en    = 1'b1;
               wr_addr  = AddrWidth'(base_cur + 32'(idx_ff));
               wr_data  = 1'b0;
               addr_in  = blk32[POOL_ORDER-1:0];
               state_in = ST_SPLIT;
            end else if (32'(idx_ff) == base_cur) begin
               // last block of this order
               if (ord_ff == PoolOrd) begin
                  status_in = STATUS_NO_SPACE;
                  state_in  = ST_DONE;
               end else begin
                  ord_in   = ord_ff + OrdWidth'(1);
                  idx_in   = '0;
                  state_in = ST_ARD;
               end
            end else begin
               idx_in   = idx_ff + POOL_ORDER'(1);
               state_in = ST_ARD;
            end
         end
         ST_SPLIT: begin
            if (ord_ff == req_ord_ff) begin
               state_in = ST_DONE;
            end else begin
               // right half one order down becomes free
               wr_en   = 1'b1;
               wr_addr = AddrWidth'(split32);
               wr_data = 1'b1;
               ord_in  = ord_dn;
            end
         end
         ST_FRD: begin
            if (ord_ff == PoolOrd) begin
               wr_en    = 1'b1;
               wr_addr  = AddrWidth'(map32);
               wr_data  = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AddrWidth'(buddy32);
               state_in = ST_FCHK;
            end
         end
         ST_FCHK: begin
            wr_en = 1'b1;
            if (rd_data) begin
               // buddy free: absorb it and go up one order
               wr_addr  = AddrWidth'(buddy32);
               wr_data  = 1'b0;
               out32    = addr32 & ~(32'd1 << ord_ff);
               addr_in  = out32[POOL_ORDER-1:0];
               ord_in   = ord_ff + OrdWidth'(1);
               state_in = ST_FRD;
            end else begin
               wr_addr  = AddrWidth'(map32);
               wr_data  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out32 = (op_ff == OP_ALLOC && status_ff == STATUS_DONE) ? addr32 : 32'd0;
               rsp_in.block_address = out32[15:0];
               rsp_in.status        = status_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== test/testbench.sv =====
// Testbench for buddy_block_allocator: random and directed allocate/free requests,
// checked against an in-bench free-bitmap model. Depends on bba_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
   import bba_pkg::*;

   localparam int unsigned PoolOrder = 16;
   localparam int unsigned MinOrder  = 7;
   localparam int unsigned MapDepth  = (2 << (PoolOrder - MinOrder)) - 1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   buddy_block_allocator #(
      .POOL_ORDER(PoolOrder),
      .MIN_ORDER (MinOrder)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // predictor state: one free bit per block, per order
   bit      free_bits [MapDepth];
   // same map advanced in queue order, for building stimulus
   bit      plan_bits [MapDepth];
   rsp_type last_plan;
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      mismatches;
   int      accepted_reqs;
   int      checked_rsps;
   int      no_space_count;
   int      bad_size_count;
   int      burst_left;
   int      gap_left;
   int      stall_phase;
   bit      hold_sender;
   bit      req_taken;
   // live allocations, used to build well-formed frees
   logic [15:0] live_addr[$];
   logic [16:0] live_size[$];

   function automatic int unsigned bit_slot(int unsigned ord, int unsigned addr);
      int unsigned slot;
      slot = ((1 << (PoolOrder - ord)) - 1) + (addr >> ord);
      return (slot < MapDepth) ? slot : 0;
   endfunction

   // rounded order, or PoolOrder+1 when the size is out of range
   function automatic int unsigned rounded_order(logic [16:0] size);
      int unsigned bits;
      logic [16:0] n;
      if (size == 0) begin
         return PoolOrder + 1;
      end
      n    = size - 1;
      bits = 0;
      while (n != 0) begin
         bits++;
         n = n >> 1;
      end
      if (bits < MinOrder) begin
         bits = MinOrder;
      end
      return (bits > PoolOrder) ? PoolOrder + 1 : bits;
   endfunction

   function automatic rsp_type allocate_or_free(req_type rq);
      rsp_type     rs;
      int unsigned ord;
      int unsigned lvl;
      int unsigned addr;
      int unsigned blk;
      int unsigned buddy;
      bit          found;
      rs   = '0;
      ord  = rounded_order(rq.size);
      addr = rq.address;
      if (ord > PoolOrder) begin
         rs.status = STATUS_BAD_SIZE;
      end else if (rq.operation == OP_ALLOC) begin
         found = 0;
         blk   = 0;
         for (int unsigned j = ord; j <= PoolOrder && !found; j++) begin
            for (int unsigned i = 0; i < (1 << (PoolOrder - j)); i++) begin
               if (free_bits[bit_slot(j, i << j)]) begin
                  free_bits[bit_slot(j, i << j)] = 0;
                  blk   = i << j;
                  found = 1;
                  break;
               end
            end
            if (found) begin
               lvl = j;
               while (lvl > ord) begin
                  lvl--;
                  free_bits[bit_slot(lvl, blk + (1 << lvl))] = 1;
               end
            end
         end
         if (found) begin
            rs.block_address = blk[15:0];
         end else begin
            rs.status = STATUS_NO_SPACE;
         end
      end else begin
         addr = addr & ~((1 << ord) - 1);
         while (ord < PoolOrder) begin
            buddy = addr ^ (1 << ord);
            if (!free_bits[bit_slot(ord, buddy)]) begin
               break;
            end
            free_bits[bit_slot(ord, buddy)] = 0;
            addr = addr & ~(1 << ord);
            ord++;
         end
         free_bits[bit_slot(ord, addr)] = 1;
      end
      return rs;
   endfunction

   // queue a request and advance the planning map in queue order
   task automatic queue_request(logic op, logic [16:0] size, logic [15:0] addr);
      req_type rq;
      bit      saved[MapDepth];
      rq.operation = op;
      rq.size      = size;
      rq.address   = addr;
      pending_reqs.push_back(rq);
      saved     = free_bits;
      free_bits = plan_bits;
      last_plan = allocate_or_free(rq);
      plan_bits = free_bits;
      free_bits = saved;
   endtask

   // biased toward small blocks, a few large
   function automatic logic [16:0] random_size();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(1, 65536);
         1:       return 17'(1) << $urandom_range(0, 16);
         default: return $urandom_range(1, 2048);
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever begin
         #1 clock = ~clock;
      end
   end

   // driver: bursts and gaps; holds valid until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (req_valid && !req_taken) begin
         // holding the current request
      end else if (gap_left > 0 || hold_sender || pending_reqs.size() == 0) begin
         req_valid <= 1'b0;
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
         end
      end else begin
         req_valid <= 1'b1;
         req_data  <= pending_reqs.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         end else begin
            burst_left <= burst_left - 1;
         end
      end
   end

   // receiver stall pattern: runs of ready and stalls of varying length
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         stall_phase <= 0;
      end else begin
         stall_phase <= stall_phase + 1;
         if (stall_phase[8]) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) < 60);
         end
      end
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      rsp_type exp_rsp;
      req_taken <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            accepted_reqs <= accepted_reqs + 1;
            expected_rsps.push_back(allocate_or_free(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            checked_rsps <= checked_rsps + 1;
            if (expected_rsps.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) begin
                  $display("ERROR: response %h with none expected", rsp_data);
               end
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (exp_rsp.status == STATUS_NO_SPACE) begin
                  no_space_count <= no_space_count + 1;
               end
               if (exp_rsp.status == STATUS_BAD_SIZE) begin
                  bad_size_count <= bad_size_count + 1;
               end
               if (rsp_data.block_address !== exp_rsp.block_address
                     || rsp_data.status !== exp_rsp.status) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10) begin
                     $display("ERROR: response %0d: addr exp %h got %h, status exp %0d got %0d",
                              checked_rsps, exp_rsp.block_address, rsp_data.block_address,
                              exp_rsp.status, rsp_data.status);
                  end
               end
            end
         end
      end
   end

   initial begin
      #30000000;
      $display("Timeout waiting for responses");
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int          pick;
      logic [16:0] sz;
      for (int i = 0; i < MapDepth; i++) begin
         free_bits[i] = 0;
         plan_bits[i] = 0;
      end
      free_bits[0]   = 1;
      plan_bits[0]   = 1;
      mismatches     = 0;
      accepted_reqs  = 0;
      checked_rsps   = 0;
      no_space_count = 0;
      bad_size_count = 0;
      burst_left     = 1;
      gap_left       = 0;
      stall_phase    = 0;
      hold_sender    = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      reset          = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: whole pool, exhaustion, size edges, buddy merges, odd frees
      queue_request(OP_ALLOC, 17'd65536, 16'hffff);
      queue_request(OP_ALLOC, 17'd1, 16'h0000);
      queue_request(OP_FREE, 17'd65536, 16'h0000);
      queue_request(OP_ALLOC, 17'd0, 16'h0000);
      queue_request(OP_FREE, 17'd0, 16'h1234);
      queue_request(OP_ALLOC, 17'd65537, 16'h0000);
      queue_request(OP_ALLOC, 17'h1ffff, 16'h0000);
      queue_request(OP_FREE, 17'h1ffff, 16'hffff);
      queue_request(OP_ALLOC, 17'd1, 16'h0000);
      queue_request(OP_ALLOC, 17'd128, 16'h0000);
      queue_request(OP_ALLOC, 17'd129, 16'h0000);
      queue_request(OP_ALLOC, 17'd32768, 16'h0000);
      queue_request(OP_ALLOC, 17'd32768, 16'h0000);
      queue_request(OP_FREE, 17'd128, 16'h007f);
      queue_request(OP_FREE, 17'd128, 16'h0080);
      queue_request(OP_FREE, 17'd128, 16'h0080);
      queue_request(OP_FREE, 17'd256, 16'h0100);
      queue_request(OP_FREE, 17'd32768, 16'h8000);
      queue_request(OP_FREE, 17'd1, 16'hffff);
      queue_request(OP_FREE, 17'd65536, 16'h5555);
      queue_request(OP_ALLOC, 17'd100, 16'haaaa);
      queue_request(OP_FREE, 17'd100, 16'h0000);
      hold_sender = 1'b0;
      wait (pending_reqs.size() == 0);

      // random: mostly alloc/free of live blocks, plus noise
      for (int n = 0; n < 1300; n++) begin
         if (n % 400 == 399) begin
            // full drain before carrying on
            wait (pending_reqs.size() == 0 && !req_valid);
            hold_sender = 1'b1;
            wait (expected_rsps.size() == 0);
            hold_sender = 1'b0;
         end
         pick = $urandom_range(0, 99);
         if (pick < 50 && live_addr.size() < 200) begin
            sz = random_size();
            queue_request(OP_ALLOC, sz, 16'($urandom));
            if (last_plan.status == STATUS_DONE) begin
               live_addr.push_back(last_plan.block_address);
               live_size.push_back(sz);
            end
         end else if (pick < 90 && live_addr.size() > 0) begin
            pick = $urandom_range(0, live_addr.size() - 1);
            queue_request(OP_FREE, live_size[pick], live_addr[pick]);
            live_addr.delete(pick);
            live_size.delete(pick);
         end else begin
            queue_request(1'($urandom), random_size() & {17{$urandom_range(0, 9) != 0}},
                          16'($urandom));
         end
      end

      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);

      $display("Covered %0d requests, %0d responses checked (%0d no-space, %0d bad-size).",
               accepted_reqs, checked_rsps, no_space_count, bad_size_count);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", mismatches,
                  expected_rsps.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
